// ----- rtl/bre_pkg.sv -----
// ----------------------------------------------------------------------------
// Bit reader package
// Shared types and constants for the MSB-first bit reader with Exp-Golomb
// decoding.
// ----------------------------------------------------------------------------
package bre_pkg;

    localparam int MAX_READ_BITS = 32;
    localparam int VALUE_W       = 32;
    localparam int ACC_W         = VALUE_W + 1;
    localparam int OP_W          = 2;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_READ   = 2'd2,
        OP_EXPG   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_FIXED,
        MODE_PREFIX,
        MODE_SUFFIX
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_SHIFT,
        S_FINISH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic init_one;
        logic shift;
    } t_acc_ctl;

endpackage

// ----- rtl/bre_byte_mem.sv -----
// ----------------------------------------------------------------------------
// Byte store
// Single-port-write, single-port-read byte memory with registered read data.
// ----------------------------------------------------------------------------
module bre_byte_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bre_bit_unit.sv -----
// ----------------------------------------------------------------------------
// Bit unit
// Picks one bit of the current byte, MSB first, and shifts it into the
// result accumulator.
// ----------------------------------------------------------------------------
module bre_bit_unit
    import bre_pkg::*;
(
    input  logic             i_clk,
    input  t_acc_ctl         i_ctl,
    input  logic [7:0]       i_byte,
    input  logic [2:0]       i_bit_idx,
    output logic             o_bit,
    output logic [ACC_W-1:0] o_acc
);

    logic [ACC_W-1:0] r_acc;

    assign o_bit = i_byte[3'd7 - i_bit_idx];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= {{(ACC_W-1){1'b0}}, i_ctl.init_one};
        end else if (i_ctl.shift) begin
            r_acc <= {r_acc[ACC_W-2:0], o_bit};
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/bitstream_reader_exp_golomb_core.sv -----
// ----------------------------------------------------------------------------
// Bitstream reader with Exp-Golomb decoding
// Byte buffer read MSB first through a bit cursor, with fixed-length reads
// and unsigned Exp-Golomb decoding.
//
//  Channel | Direction | Signals                         | Contents
//  s       | in        | tvalid tready tdata[15:0] tuser | op, byte, length
//  m       | out       | tvalid tready tdata[31:0] tuser | value, failed
//
// Clear and append requests finish in the idle state. A fixed read goes through
// check, fetch and shift, then finish and emit; a zero-length read skips to
// finish and a failed check goes to emit. An Exp-Golomb request reads its prefix
// zeros, then its suffix, one bit per cycle in shift but for each byte fetch.
// Reset clears the byte count, the cursor and the output valid, not the store.
// A finished result waits in the sequencer while the output is stalled.
// ----------------------------------------------------------------------------
module bitstream_reader_exp_golomb_core
    import bre_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [7:0] data_byte, [13:8] read_length, [15:14] zero
    input  logic [1:0]  i_s_tuser,  // [1:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [31:0] value
    output logic [0:0]  o_m_tuser   // [0] failed
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int PW = $clog2(BUFFER_BYTES * 8 + 1);
    localparam int SW = PW + 1;

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [PW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_count, n_count;
    logic [PW-1:0]       r_remain, n_remain;
    logic [VALUE_W-1:0]  r_res_value, n_res_value;
    logic                r_res_failed, n_res_failed;
    logic                r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]  r_out_value, n_out_value;
    logic                r_out_failed, n_out_failed;

    logic                w_we;
    logic [7:0]          w_rdata;
    t_acc_ctl            w_acc_ctl;
    logic                w_bit;
    logic [ACC_W-1:0]    w_acc;
    logic [SW-1:0]       w_end_bits;
    logic [SW-1:0]       w_read_end;
    logic [SW-1:0]       w_next_pos;
    t_op                 w_op;
    logic [BYTE_W-1:0]   w_byte;
    logic [LEN_W-1:0]    w_len;

    assign w_op       = t_op'(i_s_tuser);
    assign w_byte     = i_s_tdata[7:0];
    assign w_len      = i_s_tdata[13:8];
    assign w_end_bits = SW'({r_count, 3'b000});
    assign w_read_end = SW'(r_pos) + SW'(r_remain);
    assign w_next_pos = SW'(r_pos) + SW'(1);

    bre_byte_mem #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_byte),
        .i_raddr (r_pos[AW+2:3]),
        .o_rdata (w_rdata)
    );

    bre_bit_unit u_bit (
        .i_clk     (i_clk),
        .i_ctl     (w_acc_ctl),
        .i_byte    (w_rdata),
        .i_bit_idx (r_pos[2:0]),
        .o_bit     (w_bit),
        .o_acc     (w_acc)
    );

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_pos        = r_pos;
        n_count      = r_count;
        n_remain     = r_remain;
        n_res_value  = r_res_value;
        n_res_failed = r_res_failed;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_failed = r_out_failed;
        w_we         = 1'b0;
        w_acc_ctl    = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    case (w_op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_pos   = '0;
                        end
                        OP_APPEND: begin
                            if (r_count < CW'(BUFFER_BYTES)) begin
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_READ: begin
                            n_mode   = MODE_FIXED;
                            n_remain = PW'(w_len);
                            n_state  = S_CHECK;
                        end
                        OP_EXPG: begin
                            n_remain = '0;
                            if (SW'(r_pos) >= w_end_bits) begin
                                n_res_value  = '0;
                                n_res_failed = 1'b1;
                                n_state      = S_EMIT;
                            end else begin
                                n_mode  = MODE_PREFIX;
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (r_remain > PW'(MAX_READ_BITS) || w_read_end > w_end_bits) begin
                    n_res_value  = '1;
                    n_res_failed = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    w_acc_ctl.load     = 1'b1;
                    w_acc_ctl.init_one = (r_mode == MODE_SUFFIX);
                    if (r_remain == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                n_pos = r_pos + PW'(1);
                if (r_mode == MODE_PREFIX) begin
                    if (w_bit || w_next_pos >= w_end_bits) begin
                        n_mode  = MODE_SUFFIX;
                        n_state = S_CHECK;
                    end else begin
                        n_remain = r_remain + PW'(1);
                        if (r_pos[2:0] == 3'd7) begin
                            n_state = S_FETCH;
                        end
                    end
                end else begin
                    w_acc_ctl.shift = 1'b1;
                    n_remain        = r_remain - PW'(1);
                    if (r_remain == PW'(1)) begin
                        n_state = S_FINISH;
                    end else if (r_pos[2:0] == 3'd7) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FINISH: begin
                if (r_mode == MODE_SUFFIX) begin
                    n_res_value = w_acc[VALUE_W-1:0] - VALUE_W'(1);
                end else begin
                    n_res_value = w_acc[VALUE_W-1:0];
                end
                n_res_failed = 1'b0;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_failed = r_res_failed;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_FIXED;
            r_pos       <= '0;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_value  <= n_res_value;
        r_res_failed <= n_res_failed;
        r_out_value  <= n_out_value;
        r_out_failed <= n_out_failed;
    end

    assign o_s_tready   = (r_state == S_IDLE);
    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_value;
    assign o_m_tuser[0] = r_out_failed;

`ifndef SYNTHESIS
    a_cursor_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_pos) <= w_end_bits)
        else $error("Bit cursor is past the end of the buffered data.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUFFER_BYTES))
        else $error("Byte count exceeds the buffer size.");

    a_shift_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_mode != MODE_PREFIX) |-> (r_remain != '0))
        else $error("Shift step entered with no bits left to read.");

    a_read_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (SW'(r_pos) < w_end_bits))
        else $error("Bit taken beyond the buffered data.");
`endif

endmodule
